// ===== rtl/core/qsn_pkg.sv =====
// qsn_pkg: shared types and constants of the quad surface normal block
// no dependencies; used by the normaliser, the top level and the testbench
package qsn_pkg;

  // normalised magnitude width, top bit lands at bit 30
  localparam int MAG_W  = 31;
  // sum of three squared magnitudes
  localparam int SQ_W   = 64;
  // integer square root of SQ_W bits
  localparam int ROOT_W = 32;
  // width of the result normal fields
  localparam int OUT_W  = 16;

  // corner order of the triangle at each corner: apex, next, previous
  localparam logic [1:0] TRI_ORDER [4][3] = '{
    '{2'd0, 2'd1, 2'd3},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd3, 2'd1},
    '{2'd3, 2'd0, 2'd2}
  };

  // side information that travels with a vector through the normaliser
  typedef struct packed {
    logic       vld;
    logic       zero;
    logic [2:0] neg;
  } meta_t;

  // one result beat
  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } res_t;

endpackage

// ===== rtl/core/qsn_if.sv =====
// qsn_in_if / qsn_out_if: valid-ready channels of the quad surface normal block
// no dependencies on other files
interface qsn_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] c1_x, c1_y, c1_z;
  logic signed [COORD_WIDTH-1:0] c2_x, c2_y, c2_z;
  logic signed [COORD_WIDTH-1:0] c3_x, c3_y, c3_z;
  logic signed [COORD_WIDTH-1:0] c4_x, c4_y, c4_z;

  modport source (
    output valid, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z,
           c3_x, c3_y, c3_z, c4_x, c4_y, c4_z,
    input  ready
  );
  modport sink (
    input  valid, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z,
           c3_x, c3_y, c3_z, c4_x, c4_y, c4_z,
    output ready
  );
endinterface

interface qsn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

// ===== rtl/core/quad_surface_normal.sv =====
// quad_surface_normal: unit face normal of a quad from its four corners
// depends on qsn_pkg, qsn_if, qsn_lane and qsn_unit
//
//  channel | dir | beat contents                         | handshake
//  --------+-----+---------------------------------------+------------
//  in_i    | in  | c1..c4 x/y/z, signed Q8.8             | valid/ready
//  out_o   | out | normal_x/y/z signed Q1.14, degenerate | valid/ready
//
// one beat per cycle while the output queue has room; the pipe depth is set by the two
//   32-stage square-root pipes and the (NORMAL_FRAC_BITS+2)-stage dividers
// reset clears every valid bit and the output queue; payload registers are not reset
// the whole pipe advances together; it stalls only when the two-entry output queue is full,
//   so a beat waiting at the output does not hold off the input
module quad_surface_normal #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qsn_in_if.sink     in_i,
  qsn_out_if.source  out_o
);

  localparam int NQ = NORMAL_FRAC_BITS + 2;  // unit normal width
  localparam int SW = NORMAL_FRAC_BITS + 4;  // width of the sum of four unit normals

  // pipe advance: free slot in the output queue
  logic       en;
  logic [1:0] cnt_q;
  assign en       = (cnt_q != 2'd2);
  assign in_i.ready = en;

  // corners as an array
  logic signed [COORD_WIDTH-1:0] pt [4][3];
  assign pt[0] = '{in_i.c1_x, in_i.c1_y, in_i.c1_z};
  assign pt[1] = '{in_i.c2_x, in_i.c2_y, in_i.c2_z};
  assign pt[2] = '{in_i.c3_x, in_i.c3_y, in_i.c3_z};
  assign pt[3] = '{in_i.c4_x, in_i.c4_y, in_i.c4_z};

  // four lanes, one triangle each
  logic signed [COORD_WIDTH-1:0] la [4][3];
  logic signed [COORD_WIDTH-1:0] lb [4][3];
  logic signed [COORD_WIDTH-1:0] lc [4][3];
  logic signed [NQ-1:0]          ln [4][3];
  logic [3:0]                    lvld;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      for (int c = 0; c < 3; c++) begin
        la[g][c] = pt[qsn_pkg::TRI_ORDER[g][0]][c];
        lb[g][c] = pt[qsn_pkg::TRI_ORDER[g][1]][c];
        lc[g][c] = pt[qsn_pkg::TRI_ORDER[g][2]][c];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    qsn_lane #(
      .CW   (COORD_WIDTH),
      .FRAC (NORMAL_FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (in_i.valid),
      .a_i    (la[g]),
      .b_i    (lb[g]),
      .c_i    (lc[g]),
      .vld_o  (lvld[g]),
      .n_o    (ln[g])
    );
  end

  // merge: exact sum of the four triangle normals
  logic signed [SW-1:0] sum_q [3];
  logic                 sum_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else if (en) begin
      sum_vld_q <= &lvld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= SW'(ln[0][c]) + SW'(ln[1][c]) + SW'(ln[2][c]) + SW'(ln[3][c]);
      end
    end
  end

  // final normalise of the sum
  logic                 fvld, fzero;
  logic signed [NQ-1:0] fn [3];

  qsn_unit #(
    .IN_W (SW),
    .FRAC (NORMAL_FRAC_BITS)
  ) u_final (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sum_vld_q),
    .v_i    (sum_q),
    .vld_o  (fvld),
    .zero_o (fzero),
    .n_o    (fn)
  );

  // result beat, low 16 bits of the Q1.F value
  qsn_pkg::res_t res_w;
  assign res_w.normal_x   = 16'(fn[0]);
  assign res_w.normal_y   = 16'(fn[1]);
  assign res_w.normal_z   = 16'(fn[2]);
  assign res_w.degenerate = fzero;

  // two-entry output queue
  qsn_pkg::res_t fifo_q [2];
  logic          wr_q, rd_q;
  logic          push, pop;
  logic [1:0]    cnt_d;

  assign push = en && fvld;
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= res_w;
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.normal_x   = fifo_q[rd_q].normal_x;
  assign out_o.normal_y   = fifo_q[rd_q].normal_y;
  assign out_o.normal_z   = fifo_q[rd_q].normal_z;
  assign out_o.degenerate = fifo_q[rd_q].degenerate;

  // queue never overflows
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

  // a full queue holds the input off
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_i.ready)
    else $error("input ready while output queue full");

  // degenerate results carry a zero normal
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.degenerate) |->
      (out_o.normal_x == '0 && out_o.normal_y == '0 && out_o.normal_z == '0))
    else $error("degenerate result with non-zero normal");

endmodule

// ===== rtl/core/qsn_unit.sv =====
// qsn_unit: pipelined vector normaliser (align, squares, square root, three dividers)
// depends on qsn_pkg
module qsn_unit #(
  parameter int IN_W = 35,
  parameter int FRAC = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic signed [IN_W-1:0] v_i [3],
  output logic                   vld_o,
  output logic                   zero_o,
  output logic signed [FRAC+1:0] n_o [3]
);

  localparam int NW   = (IN_W > qsn_pkg::MAG_W) ? IN_W : qsn_pkg::MAG_W;
  localparam int LZ_W = $clog2(NW);
  localparam int QW   = FRAC + 2;
  localparam int DW   = qsn_pkg::MAG_W + FRAC + 2;
  localparam int RW   = qsn_pkg::ROOT_W;
  localparam int MW   = qsn_pkg::MAG_W;

  // magnitudes and signs
  logic [IN_W-1:0]       abs_w [3];
  qsn_pkg::meta_t        meta_d;
  logic [NW-1:0]         mag1_q [3];
  qsn_pkg::meta_t        m1_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      abs_w[c] = v_i[c][IN_W-1] ? unsigned'(-v_i[c]) : unsigned'(v_i[c]);
    end
    meta_d.vld  = vld_i;
    meta_d.neg  = {v_i[2][IN_W-1], v_i[1][IN_W-1], v_i[0][IN_W-1]};
    meta_d.zero = ((abs_w[0] | abs_w[1] | abs_w[2]) == '0);
  end

  // leading zero count
  logic [NW-1:0]   any_w;
  logic [LZ_W-1:0] lz_w;
  logic [LZ_W-1:0] lz2_q;
  logic [NW-1:0]   mag2_q [3];
  qsn_pkg::meta_t  m2_q;

  always_comb begin
    any_w = mag1_q[0] | mag1_q[1] | mag1_q[2];
    lz_w  = '0;
    for (int b = 0; b < NW; b++) begin
      if (any_w[b]) lz_w = LZ_W'(NW - 1 - b);
    end
  end

  // aligned magnitudes, squares and their sum
  logic [NW-1:0]              sh_w [3];
  logic [MW-1:0]              m3_q [3];
  logic [MW-1:0]              m4_q [3];
  logic [MW-1:0]              m5_q [3];
  logic [2*MW-1:0]            sq4_q [3];
  logic [qsn_pkg::SQ_W-1:0]   q5_q;
  qsn_pkg::meta_t             m3m_q, m4m_q, m5m_q;

  always_comb begin
    for (int c = 0; c < 3; c++) sh_w[c] = mag2_q[c] << lz2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q  <= '0;
      m2_q  <= '0;
      m3m_q <= '0;
      m4m_q <= '0;
      m5m_q <= '0;
    end else if (en_i) begin
      m1_q  <= meta_d;
      m2_q  <= m1_q;
      m3m_q <= m2_q;
      m4m_q <= m3m_q;
      m5m_q <= m4m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lz2_q <= lz_w;
      q5_q  <= qsn_pkg::SQ_W'(sq4_q[0]) + qsn_pkg::SQ_W'(sq4_q[1])
             + qsn_pkg::SQ_W'(sq4_q[2]);
      for (int c = 0; c < 3; c++) begin
        mag1_q[c] <= NW'(abs_w[c]);
        mag2_q[c] <= mag1_q[c];
        m3_q[c]   <= sh_w[c][NW-1 -: MW];
        sq4_q[c]  <= m3_q[c] * m3_q[c];
        m4_q[c]   <= m3_q[c];
        m5_q[c]   <= m4_q[c];
      end
    end
  end

  // square root, one result bit per stage
  logic [qsn_pkg::SQ_W-1:0] rem_s  [RW+1];
  logic [RW-1:0]            root_s [RW+1];
  logic [MW-1:0]            mm_s   [RW+1][3];
  qsn_pkg::meta_t           sm_s   [RW+1];

  assign rem_s[0]  = q5_q;
  assign root_s[0] = '0;
  assign mm_s[0]   = m5_q;
  assign sm_s[0]   = m5m_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [qsn_pkg::SQ_W:0] t_w;
    logic                   ge_w;

    assign t_w  = ((qsn_pkg::SQ_W+1)'(root_s[k]) << (B + 1))
                | ((qsn_pkg::SQ_W+1)'(1) << (2 * B));
    assign ge_w = ((qsn_pkg::SQ_W+1)'(rem_s[k]) >= t_w);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sm_s[k+1] <= '0;
      end else if (en_i) begin
        sm_s[k+1] <= sm_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= ge_w ? rem_s[k] - t_w[qsn_pkg::SQ_W-1:0] : rem_s[k];
        root_s[k+1] <= ge_w ? (root_s[k] | (RW'(1) << B)) : root_s[k];
        mm_s[k+1]   <= mm_s[k];
      end
    end
  end

  // three restoring dividers: (m * 2^F + L/2) / L
  logic [DW-1:0]  dr_s [QW+1][3];
  logic [QW-1:0]  dq_s [QW+1][3];
  logic [RW-1:0]  dl_s [QW+1];
  qsn_pkg::meta_t dm_s [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dm_s[0] <= '0;
    end else if (en_i) begin
      dm_s[0] <= sm_s[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_s[0] <= root_s[RW];
      for (int c = 0; c < 3; c++) begin
        dr_s[0][c] <= (DW'(mm_s[RW][c]) << FRAC) + DW'(root_s[RW] >> 1);
        dq_s[0][c] <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [DW-1:0] t_w;

    assign t_w = DW'(dl_s[j]) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dm_s[j+1] <= '0;
      end else if (en_i) begin
        dm_s[j+1] <= dm_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_s[j+1] <= dl_s[j];
        for (int c = 0; c < 3; c++) begin
          if (dr_s[j][c] >= t_w) begin
            dr_s[j+1][c] <= dr_s[j][c] - t_w;
            dq_s[j+1][c] <= dq_s[j][c] | (QW'(1) << B);
          end else begin
            dr_s[j+1][c] <= dr_s[j][c];
            dq_s[j+1][c] <= dq_s[j][c];
          end
        end
      end
    end
  end

  // clamp to one, apply signs
  localparam logic [QW-1:0] ONE = QW'(1) << FRAC;
  logic [QW-1:0]        cl_w  [3];
  logic signed [QW-1:0] n_q   [3];
  logic                 vld_q, zero_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cl_w[c] = (dq_s[QW][c] > ONE) ? ONE : dq_s[QW][c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      zero_q <= 1'b0;
    end else if (en_i) begin
      vld_q  <= dm_s[QW].vld;
      zero_q <= dm_s[QW].zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        if (dm_s[QW].zero) n_q[c] <= '0;
        else if (dm_s[QW].neg[c]) n_q[c] <= -signed'(cl_w[c]);
        else n_q[c] <= signed'(cl_w[c]);
      end
    end
  end

  assign vld_o  = vld_q;
  assign zero_o = zero_q;
  assign n_o    = n_q;

endmodule

// ===== rtl/core/qsn_lane.sv =====
// qsn_lane: one corner triangle, edge vectors, cross product and its unit normal
// depends on qsn_unit
module qsn_lane #(
  parameter int CW   = 16,
  parameter int FRAC = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic signed [CW-1:0]   a_i [3],
  input  logic signed [CW-1:0]   b_i [3],
  input  logic signed [CW-1:0]   c_i [3],
  output logic                   vld_o,
  output logic signed [FRAC+1:0] n_o [3]
);

  localparam int DS = (CW > 16) ? CW - 16 : 0;
  localparam int EW = CW + 1 - DS;
  localparam int PW = 2 * EW;
  localparam int XW = PW + 1;

  logic signed [CW:0]   db_w [3];
  logic signed [CW:0]   dc_w [3];
  logic signed [EW-1:0] e_q  [3];
  logic signed [EW-1:0] f_q  [3];
  logic signed [PW-1:0] p_q  [6];
  logic signed [XW-1:0] x_q  [3];
  logic [2:0]           vld_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      db_w[c] = (CW+1)'(b_i[c]) - (CW+1)'(a_i[c]);
      dc_w[c] = (CW+1)'(c_i[c]) - (CW+1)'(a_i[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        e_q[c] <= EW'(db_w[c] >>> DS);
        f_q[c] <= EW'(dc_w[c] >>> DS);
      end
      p_q[0] <= e_q[1] * f_q[2];
      p_q[1] <= e_q[2] * f_q[1];
      p_q[2] <= e_q[2] * f_q[0];
      p_q[3] <= e_q[0] * f_q[2];
      p_q[4] <= e_q[0] * f_q[1];
      p_q[5] <= e_q[1] * f_q[0];
      x_q[0] <= XW'(p_q[0]) - XW'(p_q[1]);
      x_q[1] <= XW'(p_q[2]) - XW'(p_q[3]);
      x_q[2] <= XW'(p_q[4]) - XW'(p_q[5]);
    end
  end

  qsn_unit #(
    .IN_W (XW),
    .FRAC (FRAC)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (vld_q[2]),
    .v_i    (x_q),
    .vld_o  (vld_o),
    .zero_o (),
    .n_o    (n_o)
  );

endmodule

// ===== tb/sv/quad_surface_normal_tb.sv =====
`timescale 1ns / 100ps
// quad_surface_normal_tb: checks the quad surface normal block against a bit-exact predictor
// depends on qsn_pkg, qsn_if and quad_surface_normal

module quad_surface_normal_tb;

  localparam int CW = 16;
  localparam int FB = 14;
  // pipe depth of the design, without margin
  localparam int LATENCY = 2 * FB + 87;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t c [4][3];
  } quad_t;

  // bit-exact normaliser: scale so the top bit sits at bit 30, isqrt, rounded divide
  function automatic bit unit_vector(input longint v [3], output longint n [3]);
    longint unsigned mag [3];
    longint unsigned any_bits, q, root, rem, bitp, len, r, one;
    int top;
    any_bits = 0;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      any_bits |= mag[i];
    end
    if (any_bits == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
      return 0;
    end
    for (int i = 63; i >= 0; i--)
      if (any_bits[i]) begin
        top = i;
        break;
      end
    for (int i = 0; i < 3; i++)
      mag[i] = (top > 30) ? mag[i] >> (top - 30) : mag[i] << (30 - top);
    q = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    // digit-by-digit square root
    rem = q;
    root = 0;
    bitp = 64'd1 << 62;
    while (bitp > rem) bitp >>= 2;
    while (bitp != 0) begin
      if (rem >= root + bitp) begin
        rem -= root + bitp;
        root = (root >> 1) + bitp;
      end else begin
        root >>= 1;
      end
      bitp >>= 2;
    end
    len = root;
    one = 64'd1 << FB;
    for (int i = 0; i < 3; i++) begin
      r = ((mag[i] << FB) + (len >> 1)) / len;
      if (r > one) r = one;
      n[i] = (v[i] < 0) ? -longint'(r) : longint'(r);
    end
    return 1;
  endfunction

  function automatic qsn_pkg::res_t face_normal(input quad_t qd);
    // apex, next, previous per corner
    int ord [4][3] = '{'{0, 1, 3}, '{1, 2, 0}, '{2, 3, 1}, '{3, 0, 2}};
    longint sum [3];
    longint e [3], f [3], x [3], t [3], nrm [3];
    bit ok;
    qsn_pkg::res_t r;
    sum = '{0, 0, 0};
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        e[j] = longint'(qd.c[ord[k][1]][j]) - longint'(qd.c[ord[k][0]][j]);
        f[j] = longint'(qd.c[ord[k][2]][j]) - longint'(qd.c[ord[k][0]][j]);
      end
      x[0] = e[1] * f[2] - e[2] * f[1];
      x[1] = e[2] * f[0] - e[0] * f[2];
      x[2] = e[0] * f[1] - e[1] * f[0];
      void'(unit_vector(x, t));
      for (int j = 0; j < 3; j++) sum[j] += t[j];
    end
    ok = unit_vector(sum, nrm);
    r.normal_x = nrm[0][15:0];
    r.normal_y = nrm[1][15:0];
    r.normal_z = nrm[2][15:0];
    r.degenerate = !ok;
    return r;
  endfunction

  int mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // queue of expected normals, oldest first
  class normal_scoreboard;
    qsn_pkg::res_t pending [$];

    function void note_quad(quad_t qd);
      pending.push_back(face_normal(qd));
    endfunction

    task check_normal(qsn_pkg::res_t got);
      qsn_pkg::res_t want;
      if (pending.size() == 0) begin
        report_mismatch("normal beat with none outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.normal_x !== want.normal_x)
        report_mismatch($sformatf("normal_x %0d, want %0d", got.normal_x, want.normal_x));
      if (got.normal_y !== want.normal_y)
        report_mismatch($sformatf("normal_y %0d, want %0d", got.normal_y, want.normal_y));
      if (got.normal_z !== want.normal_z)
        report_mismatch($sformatf("normal_z %0d, want %0d", got.normal_z, want.normal_z));
      if (got.degenerate !== want.degenerate)
        report_mismatch($sformatf("degenerate %0b, want %0b", got.degenerate,
                                  want.degenerate));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qsn_in_if #(.COORD_WIDTH(CW)) quad_ch ();
  qsn_out_if normal_ch ();

  quad_surface_normal #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (quad_ch.sink),
    .out_o (normal_ch.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  normal_scoreboard sb = new();

  // idle and stall rates in percent, changed between phases
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    quad_ch.valid = 1'b0;
    {quad_ch.c1_x, quad_ch.c1_y, quad_ch.c1_z} = '0;
    {quad_ch.c2_x, quad_ch.c2_y, quad_ch.c2_z} = '0;
    {quad_ch.c3_x, quad_ch.c3_y, quad_ch.c3_z} = '0;
    {quad_ch.c4_x, quad_ch.c4_y, quad_ch.c4_z} = '0;
    normal_ch.ready = 1'b0;
  end

  // receiver: random stall, check each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (normal_ch.valid && normal_ch.ready)
        sb.check_normal('{normal_ch.normal_x, normal_ch.normal_y, normal_ch.normal_z,
                          normal_ch.degenerate});
      normal_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // present one quad, holding valid until it is taken; valid stays high between beats unless the sender idles
  task automatic send_quad(input quad_t qd);
    while ($urandom_range(99) < send_idle_pct) begin
      quad_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    quad_ch.valid <= 1'b1;
    {quad_ch.c1_x, quad_ch.c1_y, quad_ch.c1_z} <= {qd.c[0][0], qd.c[0][1], qd.c[0][2]};
    {quad_ch.c2_x, quad_ch.c2_y, quad_ch.c2_z} <= {qd.c[1][0], qd.c[1][1], qd.c[1][2]};
    {quad_ch.c3_x, quad_ch.c3_y, quad_ch.c3_z} <= {qd.c[2][0], qd.c[2][1], qd.c[2][2]};
    {quad_ch.c4_x, quad_ch.c4_y, quad_ch.c4_z} <= {qd.c[3][0], qd.c[3][1], qd.c[3][2]};
    do @(posedge clk_i); while (!quad_ch.ready);
    sb.note_quad(qd);
  endtask

  task automatic stop_sending();
    quad_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom_range(3) == 0 ? 16'h8000 : 16'h7fff);
      1: return coord_t'($signed($urandom_range(512)) - 256);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // mostly random quads, some small around a base, some with repeated corners, some flat in one axis
  function automatic quad_t rand_quad();
    quad_t qd;
    int shape;
    shape = $urandom_range(9);
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 3; j++)
        qd.c[k][j] = rand_coord();
    if (shape < 3) begin
      // small quad around a random base, keeps cross products modest
      for (int k = 1; k < 4; k++)
        for (int j = 0; j < 3; j++)
          qd.c[k][j] = qd.c[0][j] + coord_t'($signed($urandom_range(64)) - 32);
    end else if (shape == 3) begin
      // collapse one corner onto another, degenerate triangles
      qd.c[$urandom_range(3)] = qd.c[$urandom_range(3)];
    end else if (shape == 4) begin
      // flat in one axis
      for (int k = 1; k < 4; k++) qd.c[k][2] = qd.c[0][2];
    end
    return qd;
  endfunction

  function automatic quad_t flat_quad(input coord_t a, input coord_t b);
    quad_t qd;
    qd.c[0] = '{0, 0, 0};
    qd.c[1] = '{a, 0, 0};
    qd.c[2] = '{a, b, 0};
    qd.c[3] = '{0, b, 0};
    return qd;
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    while (guard < LATENCY + 20) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  initial begin
    quad_t qd;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unit square, reversed winding, extremes, all-equal, collinear, x-facing, smallest quad
    send_quad(flat_quad(16'sd256, 16'sd256));
    send_quad(flat_quad(16'sd256, -16'sd256));
    send_quad(flat_quad(16'sh7fff, 16'sh7fff));
    send_quad(flat_quad(-16'sh8000, 16'sh7fff));
    send_quad(flat_quad(-16'sh8000, -16'sh8000));
    for (int k = 0; k < 4; k++) qd.c[k] = '{16'sh1234, -16'sh0100, 16'sh0042};
    send_quad(qd); // all corners equal: zero sum
    for (int k = 0; k < 4; k++) qd.c[k] = '{coord_t'(k * 100), coord_t'(k * 50), 0};
    send_quad(qd); // collinear
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 3; j++) qd.c[k][j] = ((k + j) % 2) ? 16'sh7fff : -16'sh8000;
    send_quad(qd);
    for (int k = 0; k < 4; k++) qd.c[k] = '{-16'sh8000, -16'sh8000, -16'sh8000};
    qd.c[2] = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_quad(qd);
    qd = flat_quad(16'sd256, 16'sd256);
    qd.c[1] = '{0, 16'sd256, 0};
    qd.c[3] = '{16'sd256, 0, 0};
    send_quad(qd); // same square, corners in reverse order
    qd.c[0] = '{0, 0, 0}; qd.c[1] = '{0, 0, 16'sd256};
    qd.c[2] = '{0, 16'sd256, 16'sd256}; qd.c[3] = '{0, 16'sd256, 0};
    send_quad(qd); // x-facing
    qd.c[1] = '{16'sd1, 0, 0}; qd.c[2] = '{16'sd1, 16'sd1, 0}; qd.c[3] = '{0, 16'sd1, 0};
    send_quad(qd); // smallest non-zero quad
    for (int k = 0; k < 4; k++) qd.c[k] = '{coord_t'($urandom), coord_t'($urandom), 16'shffff};
    send_quad(qd);
    stop_sending();

    // pause until the pipe is empty
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (ph == 4 ? 250 : 300) send_quad(rand_quad());
      if (ph == 1) begin
        stop_sending();
        wait_drained();
      end
    end
    stop_sending();
    recv_stall_pct = 0;
    wait_drained();

    if (mismatches == 0 && sb.pending.size() == 0)
      $display("quad_surface_normal_tb: PASS");
    else
      $display("quad_surface_normal_tb: FAIL");
    $finish;
  end

  // worst case: every beat waits out long stalls on both sides plus the pipe depth
  initial begin
    #(8ns * 400000);
    $display("quad_surface_normal_tb: FAIL");
    $finish;
  end

endmodule
